>>> hdl/mme_pkg.sv
`default_nettype none

package mme_pkg;

    // Operand and modulus width
    localparam int WIDTH = 32;

    // Bit counter width for one bit-serial product
    localparam int CNT_W = $clog2(WIDTH);

    // Input word: base in the low half, exponent in the high half
    localparam int IN_W = 2 * WIDTH;

    // Modulus after reset
    localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(23);

endpackage

`default_nettype wire

>>> hdl/mme_mulmod.sv
`default_nettype none

// Interleaved modular multiplier: one bit of the multiplier a cycle, MSB first.
// Operand a and the modulus must hold steady while busy; b is captured on start.
module mme_mulmod
    import mme_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic [WIDTH-1:0] m,
    output logic                  done,
    output logic [WIDTH-1:0]      product
);

    localparam int SUM_W = WIDTH + 2;

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] b_sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SUM_W-1:0] t;
    logic [SUM_W-1:0] m1;
    logic [SUM_W-1:0] m2;
    logic [SUM_W-1:0] t_sel;

    // 2*acc + bit*a stays below 3m, so at most two subtractions of m are needed
    always_comb
    begin
        t  = {1'b0, acc_reg, 1'b0} + {2'b00, (b_sh_reg[WIDTH-1] ? a : '0)};
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        if (t >= m2)
        begin
            t_sel = t - m2;
        end
        else if (t >= m1)
        begin
            t_sel = t - m1;
        end
        else
        begin
            t_sel = t;
        end
        acc_next = t_sel[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            b_sh_reg <= {b_sh_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> hdl/modular_exponentiation_core.sv
// Work: one reduction of the base plus k modular products (k up to 2 * WIDTH - 1) over an
// n-bit exponent; exponent zero or modulus zero skips the multiplier and goes straight
// to the finish state.
// Throughput: one word at a time; the single bit-serial multiplier sets the pace.
// Reset: rst_n asynchronous, active low; clears control and loads modulus 23.
`default_nettype none

module modular_exponentiation_core
    import mme_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // configuration: modulus
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [WIDTH-1:0] cfg_data,
    // input words
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // base_value, exponent
    // result words
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [WIDTH-1:0]      m_tdata    // power_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] r_reg;      // running result
    logic [WIDTH-1:0] b_reg;      // current square (raw base before reduction)
    logic [WIDTH-1:0] e_reg;      // exponent bits still to scan
    logic             start_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;

    logic [WIDTH-1:0] in_base;
    logic [WIDTH-1:0] in_exp;
    logic [WIDTH-1:0] mul_a;
    logic             mul_done;
    logic [WIDTH-1:0] mul_product;
    logic             out_free;

    assign in_base  = s_tdata[WIDTH-1:0];
    assign in_exp   = s_tdata[IN_W-1:WIDTH];
    assign out_free = !out_valid_reg || m_tready;

    // Squaring feeds the square on both sides; otherwise the running result
    // is the multiplicand. During reduction r holds (1 mod m), so the product
    // is the base reduced by the modulus.
    assign mul_a = (state_reg == S_SQR) ? b_reg : r_reg;

    mme_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .a       (mul_a),
        .b       (b_reg),
        .m       (modulus_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // The user must change the modulus only while idle; the block does not enforce it, cfg_ready stays high
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_valid)
        begin
            modulus_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            r_reg         <= '0;
            b_reg         <= '0;
            e_reg         <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        b_reg <= in_base;
                        e_reg <= in_exp;
                        if (in_exp == '0)
                        begin
                            // exponent zero gives one for every modulus
                            r_reg     <= WIDTH'(1);
                            state_reg <= S_FINISH;
                        end
                        else if (modulus_reg == '0)
                        begin
                            r_reg     <= '0;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            // r starts at 1 mod m: zero when the modulus is one
                            r_reg     <= (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                            start_reg <= 1'b1;
                            state_reg <= S_REDUCE;
                        end
                    end
                end

                S_REDUCE:
                begin
                    if (mul_done)
                    begin
                        b_reg     <= mul_product;
                        state_reg <= S_STEP;
                    end
                end

                S_STEP:
                begin
                    // multiply on a set bit, then square
                    start_reg <= 1'b1;
                    state_reg <= e_reg[0] ? S_MUL : S_SQR;
                end

                S_MUL:
                begin
                    if (mul_done)
                    begin
                        r_reg <= mul_product;
                        if (e_reg[WIDTH-1:1] == '0)
                        begin
                            // last set bit: the final square is not needed
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            state_reg <= S_SQR;
                        end
                    end
                end

                S_SQR:
                begin
                    if (mul_done)
                    begin
                        b_reg     <= mul_product;
                        e_reg     <= {1'b0, e_reg[WIDTH-1:1]};
                        state_reg <= S_STEP;
                    end
                end

                S_FINISH:
                begin
                    // hold the result until the output register frees up
                    if (out_free)
                    begin
                        out_data_reg  <= r_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> verif/tb_modular_exponentiation_core.sv
`default_nettype none

module tb_modular_exponentiation_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    // Cycles with no accepted word before the run is declared hung
    localparam int STALL_LIMIT   = 40000;
    // Receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES   = 6000;
    // Quiet time after the last result to catch stray words
    localparam int TAIL_CYCLES   = 2500;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASES        = 6;
    localparam int WORDS_PER_PHASE = 43;

    // Idle/stall percentages
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_HEAVY    = 71;
    localparam int IDLE_BOTH     = 33;

    localparam logic [WIDTH-1:0] ALL_ONES  = '1;
    localparam logic [WIDTH-1:0] PRIME_TOP = 32'hFFFF_FFFB;
    localparam logic [WIDTH-1:0] HALF_TOP  = 32'h8000_0000;

    typedef struct {
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] base_value;
        logic [WIDTH-1:0] exponent;
        bit               known;
        logic [WIDTH-1:0] power_result;
    } directed_case_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [WIDTH-1:0] cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [WIDTH-1:0] m_tdata;

    // Expected power results, oldest first
    logic [WIDTH-1:0] expected_power_q[$];
    directed_case_t   directed_cases[$];

    logic [WIDTH-1:0] active_modulus = MOD_RESET;
    int               sender_idle_pct = IDLE_NONE;
    int               receiver_stall_pct = IDLE_NONE;
    int               hold_requests = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;
    logic [WIDTH-1:0] wanted_power;

    modular_exponentiation_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // base_value, exponent
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // power_result
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Right-to-left square-and-multiply; full double-width products keep every
    // reduction exact. Exponent zero wins over modulus zero.
    function automatic logic [WIDTH-1:0] power_mod(input logic [WIDTH-1:0] base_value,
                                                   input logic [WIDTH-1:0] exponent,
                                                   input logic [WIDTH-1:0] modulus);
        logic [2*WIDTH-1:0] running;
        logic [2*WIDTH-1:0] square;
        logic [WIDTH-1:0]   bits_left;
        if (exponent == '0)
            return WIDTH'(1);
        if (modulus == '0)
            return '0;
        running   = (2*WIDTH)'(1) % modulus;
        square    = base_value % modulus;
        bits_left = exponent;
        while (bits_left != '0)
        begin
            if (bits_left[0])
                running = (running * square) % modulus;
            square    = (square * square) % modulus;
            bits_left = bits_left >> 1;
        end
        return running[WIDTH-1:0];
    endfunction

    function automatic void add_case(input logic [WIDTH-1:0] modulus,
                                     input logic [WIDTH-1:0] base_value,
                                     input logic [WIDTH-1:0] exponent,
                                     input bit known,
                                     input logic [WIDTH-1:0] power_result);
        directed_case_t row;
        row.modulus      = modulus;
        row.base_value   = base_value;
        row.exponent     = exponent;
        row.known        = known;
        row.power_result = power_result;
        directed_cases.push_back(row);
    endfunction

    // Drop valid and hold until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_power_q.size() != 0);
    endtask

    // Only written with the block idle
    task automatic write_modulus(input logic [WIDTH-1:0] modulus);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= modulus;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        active_modulus  = modulus;
        @(posedge clk);
    endtask

    // Offer one input word after a random idle gap; queue its expected power
    // once the block takes it
    task automatic send_word(input logic [WIDTH-1:0] base_value,
                             input logic [WIDTH-1:0] exponent,
                             input bit known,
                             input logic [WIDTH-1:0] power_result);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {exponent, base_value};
        do
            @(posedge clk);
        while (!s_tready);
        expected_power_q.push_back(known ? power_result
                                         : power_mod(base_value, exponent, active_modulus));
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge clk)
    begin : receiver
        int hold_served;
        int hold_left;
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_power_q.size() == 0)
            begin
                $display("%0t: power_result %h with nothing expected", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                wanted_power = expected_power_q.pop_front();
                if (m_tdata !== wanted_power)
                begin
                    $display("%0t: power_result expected %h actual %h",
                             $time, wanted_power, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any accepted word on any channel resets the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [WIDTH-1:0] base_value;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] next_modulus;
        int               span;

        // Directed table: modulus, base, exponent, typed-in flag, power
        // Reset modulus 23: exponent zero, zero base, Fermat, multiple of modulus
        add_case(MOD_RESET, 2, 0, 1'b1, 1);
        add_case(MOD_RESET, 0, 0, 1'b1, 1);
        add_case(MOD_RESET, ALL_ONES, 0, 1'b1, 1);
        add_case(MOD_RESET, 0, 5, 1'b1, 0);
        add_case(MOD_RESET, 1, ALL_ONES, 1'b1, 1);
        add_case(MOD_RESET, 2, 3, 1'b1, 8);
        add_case(MOD_RESET, ALL_ONES, ALL_ONES, 1'b0, 0);
        add_case(MOD_RESET, 5, 22, 1'b1, 1);
        add_case(MOD_RESET, 46, 7, 1'b1, 0);
        // Modulus one: zero unless exponent is zero
        add_case(1, 7, 5, 1'b1, 0);
        add_case(1, 7, 0, 1'b1, 1);
        add_case(1, ALL_ONES, ALL_ONES, 1'b1, 0);
        // Modulus zero: zero unless exponent is zero
        add_case(0, 3, 4, 1'b1, 0);
        add_case(0, 3, 0, 1'b1, 1);
        add_case(0, ALL_ONES, ALL_ONES, 1'b1, 0);
        // Largest moduli: minus one squared and cubed, Fermat at the top prime
        add_case(ALL_ONES, ALL_ONES - 1, 2, 1'b1, 1);
        add_case(ALL_ONES, ALL_ONES, 5, 1'b1, 0);
        add_case(ALL_ONES, 32'h1234_5678, ALL_ONES, 1'b0, 0);
        add_case(PRIME_TOP, PRIME_TOP - 1, 3, 1'b1, PRIME_TOP - 1);
        add_case(PRIME_TOP, 2, PRIME_TOP - 1, 1'b1, 1);
        add_case(HALF_TOP, 3, HALF_TOP, 1'b0, 0);
        add_case(HALF_TOP, HALF_TOP, 2, 1'b1, 0);
        add_case(2, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
        begin
            if (directed_cases[i].modulus != active_modulus)
                write_modulus(directed_cases[i].modulus);
            send_word(directed_cases[i].base_value, directed_cases[i].exponent,
                      directed_cases[i].known, directed_cases[i].power_result);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    next_modulus = PRIME_TOP;
                    sender_idle_pct = IDLE_NONE;
                    receiver_stall_pct = IDLE_NONE;
                end
                1:
                begin
                    next_modulus = $urandom;
                    sender_idle_pct = IDLE_HEAVY;
                    receiver_stall_pct = IDLE_NONE;
                end
                2:
                begin
                    next_modulus = $urandom_range(1000, 2);
                    sender_idle_pct = IDLE_NONE;
                    receiver_stall_pct = IDLE_HEAVY;
                end
                3:
                begin
                    next_modulus = ALL_ONES;
                    sender_idle_pct = IDLE_BOTH;
                    receiver_stall_pct = IDLE_BOTH;
                end
                4:
                begin
                    next_modulus = $urandom | HALF_TOP;
                    sender_idle_pct = IDLE_NONE;
                    receiver_stall_pct = IDLE_NONE;
                end
                default:
                begin
                    next_modulus = $urandom;
                    sender_idle_pct = IDLE_NONE;
                    receiver_stall_pct = IDLE_NONE;
                end
            endcase
            write_modulus(next_modulus);

            // Back up the output while the sender keeps pushing words
            if (phase == 4)
                hold_requests++;

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Pause mid-phase until the block has emptied out
                if (phase == 1 && n == WORDS_PER_PHASE / 2)
                    wait_drained();

                case ($urandom_range(9))
                    0: base_value = '0;
                    1: base_value = active_modulus - 1;
                    2: base_value = ALL_ONES;
                    3: base_value = 1;
                    default: base_value = $urandom;
                endcase

                // Mostly short exponents keep the run fast; a quarter use all bits
                case ($urandom_range(19))
                    0: exponent = '0;
                    1: exponent = ALL_ONES;
                    2, 3, 4, 5: exponent = $urandom;
                    default:
                    begin
                        span = $urandom_range(12, 1);
                        exponent = ($urandom & ((WIDTH'(1) << span) - 1))
                                   | (WIDTH'(1) << (span - 1));
                    end
                endcase

                send_word(base_value, exponent, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_power_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
